// File: src/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants for the circular deque
// depth, index width, operation and status codes, control structs
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int DEPTH  = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int DATA_W = 32;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic accept;
    logic capture;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pop_hit;
  } dp_stat_t;

  function automatic idx_t wrap_next(input idx_t i);
    return (i == idx_t'(DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
  endfunction

  function automatic idx_t wrap_prev(input idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : idx_t'(i - 1'b1);
  endfunction

endpackage

// File: src/cdq_if.sv
// ----------------------------------------------------------------------------
// cdq_if: request and result channels of the circular deque
// valid/ready handshake with the operation or result payload
// ----------------------------------------------------------------------------
interface cdq_req_if;
  import cdq_pkg::*;

  logic               valid;
  logic               ready;
  mode_t              mode;
  logic signed [31:0] data_in;

  modport source (output valid, mode, data_in, input ready);
  modport sink   (input valid, mode, data_in, output ready);
endinterface

interface cdq_rsp_if;
  import cdq_pkg::*;

  logic               valid;
  logic               ready;
  status_t            status;
  logic signed [31:0] data_out;
  logic               now_empty;
  logic               now_full;

  modport source (output valid, status, data_out, now_empty, now_full, input ready);
  modport sink   (input valid, status, data_out, now_empty, now_full, output ready);
endinterface

// File: src/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque: double-ended queue in a ring store
// push and pop at either end, refusals flagged, empty and full reported
//
//   channel  dir  handshake          payload
//   req      in   req.valid/ready    mode, data_in
//   rsp      out  rsp.valid/ready    status, data_out, now_empty, now_full
//
// one request at a time: a push or a refused request shows its result in the
// cycle after the request edge; a pop passes the registered read of the ring
// ram and then the result register before its result shows
// the result holds until rsp.ready; req.ready stays low meanwhile
// reset (rst, synchronous) empties the deque at once, no clearing pass
// ----------------------------------------------------------------------------
module circular_deque (
  input logic  clk,
  input logic  rst,
  cdq_req_if.sink   req,
  cdq_rsp_if.source rsp
);
  import cdq_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cdq_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .mode      (req.mode),
    .data_in   (req.data_in),
    .status    (rsp.status),
    .data_out  (rsp.data_out),
    .now_empty (rsp.now_empty),
    .now_full  (rsp.now_full)
  );

endmodule

// File: src/cdq_ram.sv
// ----------------------------------------------------------------------------
// cdq_ram: generic single-write, single-read ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: src/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl: handshake controller of the circular deque
// takes one request, waits on the ram read for pops of a non-empty deque, holds the result
// ----------------------------------------------------------------------------
module cdq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  cdq_pkg::dp_stat_t  stat,
  output cdq_pkg::ctrl_cmd_t cmd
);
  import cdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE     = 3'b001,
    S_POP_WAIT = 3'b010,
    S_HOLD     = 3'b100
  } state_t;

  state_t state, state_next;

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_HOLD);
  assign cmd.accept  = in_valid && in_ready;
  assign cmd.capture = (state == S_POP_WAIT);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.accept) begin
          state_next = stat.pop_hit ? S_POP_WAIT : S_HOLD;
        end
      end
      S_POP_WAIT: begin
        state_next = S_HOLD;
      end
      S_HOLD: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("request taken while a result is pending");

  a_pop_waits: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && stat.pop_hit) |=> (cmd.capture ##1 out_valid))
    else $error("pop result not captured after ram read");

  a_push_direct: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && !stat.pop_hit) |=> out_valid)
    else $error("result not presented after request");

endmodule

// File: src/cdq_datapath.sv
// ----------------------------------------------------------------------------
// cdq_datapath: index registers, ring store and result registers
// moves head and tail, writes pushes, reads pops, forms the result
// ----------------------------------------------------------------------------
module cdq_datapath (
  input  logic               clk,
  input  logic               rst,
  input  cdq_pkg::ctrl_cmd_t cmd,
  output cdq_pkg::dp_stat_t  stat,
  input  cdq_pkg::mode_t     mode,
  input  logic signed [31:0] data_in,
  output cdq_pkg::status_t   status,
  output logic signed [31:0] data_out,
  output logic               now_empty,
  output logic               now_full
);
  import cdq_pkg::*;

  idx_t              head_idx, head_next;
  idx_t              tail_idx, tail_next;
  logic              empty_flag, empty_next;
  logic              full_now;
  logic              is_push;
  status_t           res_status;
  logic              wr_en;
  idx_t              wr_addr;
  idx_t              rd_addr;
  logic [DATA_W-1:0] rd_data;

  assign full_now = !empty_flag && (wrap_next(tail_idx) == head_idx);
  assign is_push  = (mode == MODE_PUSH_FRONT) || (mode == MODE_PUSH_BACK);
  assign stat.pop_hit = !is_push && !empty_flag;
  assign rd_addr  = (mode == MODE_POP_FRONT) ? head_idx : tail_idx;

  always_comb begin
    head_next  = head_idx;
    tail_next  = tail_idx;
    empty_next = empty_flag;
    wr_en      = 1'b0;
    wr_addr    = head_idx;
    res_status = ST_DONE;
    if (is_push) begin
      if (full_now) begin
        res_status = ST_FULL;
      end else if (empty_flag) begin
        head_next  = '0;
        tail_next  = '0;
        empty_next = 1'b0;
        wr_en      = cmd.accept;
        wr_addr    = '0;
      end else if (mode == MODE_PUSH_FRONT) begin
        head_next = wrap_prev(head_idx);
        wr_en     = cmd.accept;
        wr_addr   = head_next;
      end else begin
        tail_next = wrap_next(tail_idx);
        wr_en     = cmd.accept;
        wr_addr   = tail_next;
      end
    end else begin
      if (empty_flag) begin
        res_status = ST_EMPTY;
      end else if (head_idx == tail_idx) begin
        head_next  = '0;
        tail_next  = '0;
        empty_next = 1'b1;
      end else if (mode == MODE_POP_FRONT) begin
        head_next = wrap_next(head_idx);
      end else begin
        tail_next = wrap_prev(tail_idx);
      end
    end
  end

  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data ($unsigned(data_in)),
    .rd_en   (cmd.accept && stat.pop_hit),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head_idx   <= '0;
      tail_idx   <= '0;
      empty_flag <= 1'b1;
    end else if (cmd.accept) begin
      head_idx   <= head_next;
      tail_idx   <= tail_next;
      empty_flag <= empty_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status   <= res_status;
      data_out <= '0;
    end else if (cmd.capture) begin
      data_out <= $signed(rd_data);
    end
  end

  assign now_empty = empty_flag;
  assign now_full  = full_now;

  a_empty_idx: assert property (@(posedge clk) disable iff (rst)
    empty_flag |-> (head_idx == '0 && tail_idx == '0))
    else $error("empty deque with nonzero index");

  a_refuse_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && is_push && full_now) |=>
      ($stable(head_idx) && $stable(tail_idx) && !empty_flag))
    else $error("refused push changed the indices");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && is_push) |=> !empty_flag)
    else $error("deque empty after a push");

endmodule
